### rtl/dtfp_pkg.sv
// Shared constants, types and tables for the decimal text to fixed point parser.
package dtfp_pkg;

    localparam int FRAC_BITS       = 32;
    localparam int MAX_FRAC_DIGITS = 9;
    localparam int CNT_W           = $clog2(FRAC_BITS + 1);

    localparam logic [30:0] INT_MAX = 31'h7FFF_FFFF;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_INT   = 2'd1,
        PH_FRAC  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        S_PARSE = 2'd0,
        S_DIV   = 2'd1,
        S_HOLD  = 2'd2
    } t_state;

    function automatic logic [29:0] pow10(input logic [3:0] n);
        logic [29:0] p;
        case (n)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            4'd9:    p = 30'd1000000000;
            default: p = 30'd1;
        endcase
        return p;
    endfunction

endpackage

### rtl/dtfp_div.sv
// Bit-serial restoring divider for the fraction digits, one quotient bit per cycle.
module dtfp_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [29:0]                    i_num,
    input  logic [29:0]                    i_den,
    output logic                           o_done,
    output logic [dtfp_pkg::FRAC_BITS-1:0] o_quo
);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [29:0]                    r_rem, n_rem;
    logic [29:0]                    r_den, n_den;
    logic [dtfp_pkg::FRAC_BITS-1:0] r_quo, n_quo;
    logic [dtfp_pkg::CNT_W-1:0]     r_cnt, n_cnt;

    logic [30:0] shifted;
    logic [31:0] diff;
    logic        ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
    end

    always_comb begin
        shifted = {r_rem, 1'b0};
        diff    = {1'b0, shifted} - {2'b00, r_den};
        ge      = !diff[31];
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_rem   = r_rem;
        n_den   = r_den;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_rem  = i_num;
            n_den  = i_den;
            n_quo  = '0;
            n_cnt  = dtfp_pkg::CNT_W'(dtfp_pkg::FRAC_BITS);
        end else if (r_busy) begin
            n_rem = ge ? diff[29:0] : shifted[29:0];
            n_quo = {r_quo[dtfp_pkg::FRAC_BITS-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == dtfp_pkg::CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### rtl/decimal_text_to_fixed_point_core.sv
// Top level of the decimal text to fixed point parser.
// The block takes one ASCII character per item and returns one signed Q31.32 number, with a
// saturation flag, when a character ends the number. Whitespace, signs, the decimal point and
// digits are taken directly while the block is ready. A terminating character starts the fraction
// division, which produces one quotient bit per cycle in a bit-serial restoring divider, so the
// block is not ready until that division is done; the next item is then taken even while the
// result still waits in the output register, unless a second number ends before that result
// is taken.
module decimal_text_to_fixed_point_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_ch,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [63:0] o_value,
    output logic               o_saturated
);

    dtfp_pkg::t_state r_state, n_state;
    dtfp_pkg::t_phase r_phase, n_phase;
    logic             r_neg, n_neg;
    logic [30:0]      r_int, n_int;
    logic             r_ovf, n_ovf;
    logic [29:0]      r_frac, n_frac;
    logic [3:0]       r_fdig, n_fdig;
    logic             r_lneg, n_lneg;
    logic [30:0]      r_lint, n_lint;
    logic             r_lovf, n_lovf;
    logic             r_ovalid, n_ovalid;
    logic [63:0]      r_value, n_value;
    logic             r_sat, n_sat;

    logic                           accept;
    logic                           is_digit;
    logic                           is_space;
    logic [3:0]                     dval;
    logic [34:0]                    int_prod;
    logic [33:0]                    frac_prod;
    logic                           div_start;
    logic                           div_done;
    logic [dtfp_pkg::FRAC_BITS-1:0] div_quo;
    logic [63:0]                    mag;
    logic                           out_free;

    dtfp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_frac),
        .i_den   (dtfp_pkg::pow10(r_fdig)),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dtfp_pkg::S_PARSE;
            r_phase  <= dtfp_pkg::PH_START;
            r_neg    <= 1'b0;
            r_int    <= '0;
            r_ovf    <= 1'b0;
            r_frac   <= '0;
            r_fdig   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            r_int    <= n_int;
            r_ovf    <= n_ovf;
            r_frac   <= n_frac;
            r_fdig   <= n_fdig;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lneg  <= n_lneg;
        r_lint  <= n_lint;
        r_lovf  <= n_lovf;
        r_value <= n_value;
        r_sat   <= n_sat;
    end

    always_comb begin
        accept    = i_valid && (r_state == dtfp_pkg::S_PARSE);
        is_digit  = (i_ch >= dtfp_pkg::CH_ZERO) && (i_ch <= dtfp_pkg::CH_NINE);
        is_space  = (i_ch == dtfp_pkg::CH_SPACE) || (i_ch == dtfp_pkg::CH_TAB) ||
                    (i_ch == dtfp_pkg::CH_LF) || (i_ch == dtfp_pkg::CH_CR) ||
                    (i_ch == dtfp_pkg::CH_VT) || (i_ch == dtfp_pkg::CH_FF);
        dval      = 4'(i_ch - dtfp_pkg::CH_ZERO);
        int_prod  = ({4'b0, r_int} << 3) + ({4'b0, r_int} << 1) + 35'(dval);
        frac_prod = ({4'b0, r_frac} << 3) + ({4'b0, r_frac} << 1) + 34'(dval);
        mag       = (64'(r_lint) << dtfp_pkg::FRAC_BITS) | 64'(div_quo);
        out_free  = !r_ovalid || i_ready;

        n_state   = r_state;
        n_phase   = r_phase;
        n_neg     = r_neg;
        n_int     = r_int;
        n_ovf     = r_ovf;
        n_frac    = r_frac;
        n_fdig    = r_fdig;
        n_lneg    = r_lneg;
        n_lint    = r_lint;
        n_lovf    = r_lovf;
        n_ovalid  = r_ovalid && !i_ready;
        n_value   = r_value;
        n_sat     = r_sat;
        div_start = 1'b0;

        case (r_state)
            dtfp_pkg::S_PARSE: begin
                if (accept) begin
                    if ((r_phase != dtfp_pkg::PH_INT) && (r_phase != dtfp_pkg::PH_FRAC) &&
                        is_space) begin
                        n_phase = r_phase;
                    end else if ((r_phase != dtfp_pkg::PH_INT) &&
                                 (r_phase != dtfp_pkg::PH_FRAC) &&
                                 ((i_ch == dtfp_pkg::CH_PLUS) ||
                                  (i_ch == dtfp_pkg::CH_MINUS))) begin
                        n_neg   = (i_ch == dtfp_pkg::CH_MINUS);
                        n_phase = dtfp_pkg::PH_INT;
                    end else if ((r_phase != dtfp_pkg::PH_FRAC) && is_digit) begin
                        n_phase = dtfp_pkg::PH_INT;
                        if (r_ovf || (int_prod > 35'(dtfp_pkg::INT_MAX))) begin
                            n_int = dtfp_pkg::INT_MAX;
                            n_ovf = 1'b1;
                        end else begin
                            n_int = int_prod[30:0];
                        end
                    end else if ((r_phase != dtfp_pkg::PH_FRAC) &&
                                 (i_ch == dtfp_pkg::CH_POINT)) begin
                        n_phase = dtfp_pkg::PH_FRAC;
                    end else if ((r_phase == dtfp_pkg::PH_FRAC) && is_digit) begin
                        if (r_fdig < 4'(dtfp_pkg::MAX_FRAC_DIGITS)) begin
                            n_frac = frac_prod[29:0];
                            n_fdig = r_fdig + 4'd1;
                        end
                    end else begin
                        div_start = 1'b1;
                        n_state   = dtfp_pkg::S_DIV;
                        n_lneg    = r_neg;
                        n_lint    = r_int;
                        n_lovf    = r_ovf;
                        n_phase   = dtfp_pkg::PH_START;
                        n_neg     = 1'b0;
                        n_int     = '0;
                        n_ovf     = 1'b0;
                        n_frac    = '0;
                        n_fdig    = '0;
                    end
                end
            end
            dtfp_pkg::S_DIV, dtfp_pkg::S_HOLD: begin
                if (div_done || (r_state == dtfp_pkg::S_HOLD)) begin
                    if (out_free) begin
                        n_ovalid = 1'b1;
                        n_value  = r_lneg ? (64'd0 - mag) : mag;
                        n_sat    = r_lovf;
                        n_state  = dtfp_pkg::S_PARSE;
                    end else begin
                        n_state = dtfp_pkg::S_HOLD;
                    end
                end
            end
            default: begin
                n_state = dtfp_pkg::S_PARSE;
            end
        endcase
    end

    assign o_ready     = (r_state == dtfp_pkg::S_PARSE);
    assign o_valid     = r_ovalid;
    assign o_value     = r_value;
    assign o_saturated = r_sat;

endmodule
